FILE: rtl/crt_pkg.sv
// Shared types, constants and helpers for the contiguous run tracker.
// No dependencies; used by every module of the block.
package crt_pkg;

    localparam int POS_W       = 17;
    localparam int NODE_AW     = 17;
    localparam int NODE_DEPTH  = 1 << NODE_AW;
    localparam int LEVELS      = 17;
    localparam int LVL_W       = 5;
    localparam int STACK_AW    = 16;
    localparam int STACK_DEPTH = 1 << STACK_AW;

    localparam logic [POS_W-1:0] MAX_LEN    = POS_W'(65536);
    localparam logic [POS_W-1:0] STACK_FULL = POS_W'(STACK_DEPTH);

    typedef enum logic [1:0] {
        MODE_REMOVE  = 2'd0,
        MODE_RESTORE = 2'd1,
        MODE_QUERY   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SIDE_ROOT  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } side_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_DOWN,
        ST_LEAF,
        ST_UP_RD,
        ST_UP_WR,
        ST_Q_RD,
        ST_Q_EVAL,
        ST_SIB_RD,
        ST_SIB_EVAL,
        ST_Q_OUT
    } state_t;

    // full: node untouched since clear, runs equal the node's range length
    typedef struct packed {
        logic             full;
        logic [POS_W-1:0] lrun;
        logic [POS_W-1:0] rrun;
    } node_t;

    typedef struct packed {
        logic [POS_W-1:0] lrun;
        logic [POS_W-1:0] rrun;
    } run_pair_t;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        node_t              wdata;
        logic [NODE_AW-1:0] raddr;
    } node_req_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [POS_W-1:0] data;
    } stack_req_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [POS_W-1:0] count;
        logic [POS_W-1:0] top;
    } stack_stat_t;

    function automatic run_pair_t node_runs(node_t n, logic [POS_W-1:0] len);
        run_pair_t r;
        if (n.full)
        begin
            r.lrun = len;
            r.rrun = len;
        end
        else
        begin
            r.lrun = n.lrun;
            r.rrun = n.rrun;
        end
        return r;
    endfunction

endpackage

FILE: rtl/crt_node_mem.sv
// Segment tree node store: one write port, one registered read port.
// Depends on crt_pkg.
module crt_node_mem (
    input  logic               clk,
    input  crt_pkg::node_req_t req,
    output crt_pkg::node_t     rdata
);
    import crt_pkg::*;

    node_t mem [0:NODE_DEPTH-1];
    node_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/crt_stack.sv
// Stack of removed positions with fill count and registered top read.
// Depends on crt_pkg.
module crt_stack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crt_pkg::stack_req_t  req,
    output crt_pkg::stack_stat_t stat
);
    import crt_pkg::*;

    logic [POS_W-1:0] mem [0:STACK_DEPTH-1];
    logic [POS_W-1:0] count_reg;
    logic [POS_W-1:0] count_next;
    logic [POS_W-1:0] top_reg;
    logic [POS_W-1:0] rd_ptr;
    logic             full;
    logic             empty;

    assign full   = (count_reg == STACK_FULL);
    assign empty  = (count_reg == '0);
    assign rd_ptr = count_reg - 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (req.clear)
        begin
            count_next = '0;
        end
        else if (req.push && !full)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (req.pop && !empty)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push && !full)
        begin
            mem[count_reg[STACK_AW-1:0]] <= req.data;
        end
        top_reg <= mem[rd_ptr[STACK_AW-1:0]];
    end

    assign stat.empty = empty;
    assign stat.full  = full;
    assign stat.count = count_reg;
    assign stat.top   = top_reg;

endmodule

FILE: rtl/crt_seq.sv
// Sequencer and shared datapath: clear sweep, tree update walk, run query walk.
// Depends on crt_pkg; drives crt_node_mem and crt_stack.
module crt_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [crt_pkg::POS_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 mode,
    input  logic [crt_pkg::POS_W-1:0]  position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [crt_pkg::POS_W-1:0]  run_length,
    output crt_pkg::node_req_t         node_req,
    input  crt_pkg::node_t             node_rdata,
    output crt_pkg::stack_req_t        stack_req,
    input  crt_pkg::stack_stat_t       stack_stat
);
    import crt_pkg::*;

    state_t           state_reg, state_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             intact_reg, intact_next;
    logic [NODE_AW-1:0] node_reg, node_next;
    logic [POS_W-1:0] lo_reg, lo_next;
    logic [POS_W-1:0] hi_reg, hi_next;
    logic [POS_W-1:0] plo_reg, plo_next;
    logic [POS_W-1:0] phi_reg, phi_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    side_t            side_reg, side_next;
    run_pair_t        cur_reg, cur_next;
    logic [POS_W-1:0] run_reg, run_next;
    logic [NODE_AW-1:0] clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] out_reg, out_next;
    logic [POS_W-1:0] lo_stk_reg [0:LEVELS-1];
    logic [POS_W-1:0] hi_stk_reg [0:LEVELS-1];

    logic             pos_ok, top_ok, out_free;
    logic [POS_W-1:0] cfg_len;
    logic [POS_W:0]   sum;
    logic [POS_W-1:0] mid;
    logic [LVL_W-1:0] lvl_m1;
    logic [POS_W-1:0] plo, phi, pmid;
    logic [POS_W:0]   psum;
    logic             is_left;
    run_pair_t        up_sib, up_l, up_r, up_new;
    logic [POS_W-1:0] len_l, len_r;
    run_pair_t        qr, sr;
    logic [POS_W-1:0] need_r, need_l;
    logic             hit_r, hit_l;

    assign pos_ok   = (position != '0) && (position <= len_reg);
    assign top_ok   = (stack_stat.top != '0) && (stack_stat.top <= len_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cfg_len = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_len = POS_W'(1);
        end
        else if (cfg_data > MAX_LEN)
        begin
            cfg_len = MAX_LEN;
        end
    end

    // down / query split point
    assign sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid = sum[POS_W:1];

    // update: combine child and sibling into parent
    assign lvl_m1  = lvl_reg - 1'b1;
    assign plo     = lo_stk_reg[lvl_m1];
    assign phi     = hi_stk_reg[lvl_m1];
    assign psum    = {1'b0, plo} + {1'b0, phi};
    assign pmid    = psum[POS_W:1];
    assign len_l   = pmid - plo + 1'b1;
    assign len_r   = phi - pmid;
    assign is_left = !node_reg[0];
    assign up_sib  = node_runs(node_rdata, is_left ? len_r : len_l);
    assign up_l    = is_left ? cur_reg : up_sib;
    assign up_r    = is_left ? up_sib : cur_reg;
    assign up_new.lrun = (up_l.lrun == len_l) ? len_l + up_r.lrun : up_l.lrun;
    assign up_new.rrun = (up_r.rrun == len_r) ? len_r + up_l.rrun : up_r.rrun;

    // query at current node
    assign qr     = node_runs(node_rdata, hi_reg - lo_reg + 1'b1);
    assign need_r = hi_reg - pos_reg + 1'b1;
    assign need_l = pos_reg - lo_reg + 1'b1;
    assign hit_r  = (qr.rrun >= need_r);
    assign hit_l  = (qr.lrun >= need_l);
    assign sr     = node_runs(node_rdata,
                              (side_reg == SIDE_LEFT) ? phi_reg - hi_reg : lo_reg - plo_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_REMOVE:  state_next = pos_ok ? ST_DOWN : ST_IDLE;
                        MODE_RESTORE: state_next = stack_stat.empty ? ST_IDLE : ST_POP;
                        MODE_QUERY:   state_next = pos_ok ? ST_Q_RD : ST_Q_OUT;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POP:      state_next = top_ok ? ST_DOWN : ST_IDLE;
            ST_DOWN:     state_next = (lo_reg == hi_reg) ? ST_LEAF : ST_DOWN;
            ST_LEAF:     state_next = (lvl_reg == '0) ? ST_IDLE : ST_UP_RD;
            ST_UP_RD:    state_next = ST_UP_WR;
            ST_UP_WR:    state_next = (lvl_reg == LVL_W'(1)) ? ST_IDLE : ST_UP_RD;
            ST_Q_RD:     state_next = ST_Q_EVAL;
            ST_Q_EVAL:
            begin
                if (hit_r || hit_l)
                begin
                    state_next = (side_reg == SIDE_ROOT) ? ST_Q_OUT : ST_SIB_RD;
                end
                else
                begin
                    state_next = (lo_reg == hi_reg) ? ST_Q_OUT : ST_Q_RD;
                end
            end
            ST_SIB_RD:   state_next = ST_SIB_EVAL;
            ST_SIB_EVAL: state_next = ST_Q_OUT;
            ST_Q_OUT:    state_next = out_free ? ST_IDLE : ST_Q_OUT;
            default:     state_next = ST_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

    // datapath and memory control
    always_comb
    begin
        len_next       = len_reg;
        pos_next       = pos_reg;
        intact_next    = intact_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        lvl_next       = lvl_reg;
        side_next      = side_reg;
        cur_next       = cur_reg;
        run_next       = run_reg;
        clr_next       = clr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        node_req       = '0;
        stack_req      = '0;
        stack_req.data = position;

        unique case (state_reg)
            ST_CLEAR:
            begin
                node_req.we         = 1'b1;
                node_req.waddr      = clr_reg;
                node_req.wdata.full = 1'b1;
                clr_next            = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                pos_next  = position;
                lo_next   = POS_W'(1);
                hi_next   = len_reg;
                node_next = NODE_AW'(1);
                lvl_next  = '0;
                side_next = SIDE_ROOT;
                run_next  = '0;
                if (in_valid)
                begin
                    case (mode)
                        MODE_REMOVE:
                        begin
                            intact_next    = 1'b0;
                            stack_req.push = pos_ok;
                        end
                        MODE_RESTORE:
                        begin
                            stack_req.pop = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                pos_next    = stack_stat.top;
                intact_next = 1'b1;
            end
            ST_DOWN:
            begin
                if (lo_reg != hi_reg)
                begin
                    lvl_next = lvl_reg + 1'b1;
                    if (pos_reg > mid)
                    begin
                        lo_next   = mid + 1'b1;
                        node_next = {node_reg[NODE_AW-2:0], 1'b1};
                    end
                    else
                    begin
                        hi_next   = mid;
                        node_next = {node_reg[NODE_AW-2:0], 1'b0};
                    end
                end
            end
            ST_LEAF:
            begin
                node_req.we         = 1'b1;
                node_req.waddr      = node_reg;
                node_req.wdata.full = 1'b0;
                node_req.wdata.lrun = POS_W'(intact_reg);
                node_req.wdata.rrun = POS_W'(intact_reg);
                cur_next.lrun       = POS_W'(intact_reg);
                cur_next.rrun       = POS_W'(intact_reg);
            end
            ST_UP_RD:
            begin
                node_req.raddr = {node_reg[NODE_AW-1:1], !node_reg[0]};
            end
            ST_UP_WR:
            begin
                node_req.we         = 1'b1;
                node_req.waddr      = {1'b0, node_reg[NODE_AW-1:1]};
                node_req.wdata.full = 1'b0;
                node_req.wdata.lrun = up_new.lrun;
                node_req.wdata.rrun = up_new.rrun;
                cur_next            = up_new;
                node_next           = {1'b0, node_reg[NODE_AW-1:1]};
                lvl_next            = lvl_m1;
            end
            ST_Q_RD:
            begin
                node_req.raddr = node_reg;
            end
            ST_Q_EVAL:
            begin
                if (hit_r)
                begin
                    run_next = qr.rrun;
                end
                else if (hit_l)
                begin
                    run_next = qr.lrun;
                end
                else if (lo_reg == hi_reg)
                begin
                    run_next = '0;
                end
                else
                begin
                    plo_next = lo_reg;
                    phi_next = hi_reg;
                    if (pos_reg > mid)
                    begin
                        lo_next   = mid + 1'b1;
                        node_next = {node_reg[NODE_AW-2:0], 1'b1};
                        side_next = SIDE_RIGHT;
                    end
                    else
                    begin
                        hi_next   = mid;
                        node_next = {node_reg[NODE_AW-2:0], 1'b0};
                        side_next = SIDE_LEFT;
                    end
                end
            end
            ST_SIB_RD:
            begin
                node_req.raddr = (side_reg == SIDE_LEFT) ? node_reg + 1'b1
                                                         : node_reg - 1'b1;
            end
            ST_SIB_EVAL:
            begin
                run_next = run_reg + ((side_reg == SIDE_LEFT) ? sr.lrun : sr.rrun);
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    out_next       = run_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            len_next        = cfg_len;
            clr_next        = '0;
            stack_req.clear = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            len_reg       <= MAX_LEN;
            clr_reg       <= '0;
            lvl_reg       <= '0;
            side_reg      <= SIDE_ROOT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            clr_reg       <= clr_next;
            lvl_reg       <= lvl_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        intact_reg <= intact_next;
        node_reg   <= node_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        plo_reg    <= plo_next;
        phi_reg    <= phi_next;
        cur_reg    <= cur_next;
        run_reg    <= run_next;
        out_reg    <= out_next;
        if (state_reg == ST_DOWN)
        begin
            lo_stk_reg[lvl_reg] <= lo_reg;
            hi_stk_reg[lvl_reg] <= hi_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign run_length = out_reg;

endmodule

FILE: rtl/contiguous_run_tracker_top.sv
// channel   dir  handshake             payload
// cfg       in   cfg_we                cfg_data[16:0] (line_length)
// in        in   in_valid / in_stall   mode[1:0], position[16:0]
// out       out  out_valid / out_stall run_length[16:0]
//
// Remove: accept, down walk to the leaf, leaf write, then sibling read and parent write
// per level; restore adds a pop first. Query: node read and evaluate per level visited,
// plus sibling read and evaluate on a hit below the root; out of range skips the walk.
// Reset and every cfg write run a clear sweep over all 131072 entries of the node
// memory; in_stall is high throughout. A result waits in the output register
// while out_stall is high; the next query holds only when that register is full.
// Top level: joins crt_seq, crt_node_mem and crt_stack; depends on crt_pkg.
module contiguous_run_tracker_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [crt_pkg::POS_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic [crt_pkg::POS_W-1:0] position,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [crt_pkg::POS_W-1:0] run_length
);
    import crt_pkg::*;

    node_req_t   node_req;
    node_t       node_rdata;
    stack_req_t  stack_req;
    stack_stat_t stack_stat;

    crt_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .run_length (run_length),
        .node_req   (node_req),
        .node_rdata (node_rdata),
        .stack_req  (stack_req),
        .stack_stat (stack_stat)
    );

    crt_node_mem u_node_mem (
        .clk   (clk),
        .req   (node_req),
        .rdata (node_rdata)
    );

    crt_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stack_req),
        .stat  (stack_stat)
    );

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("cfg write did not start clear sweep");

    a_tree_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        node_req.we |-> in_stall)
        else $error("node write while idle");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_stat.count <= STACK_FULL)
        else $error("stack count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (stack_req.pop && stack_stat.empty) |=> stack_stat.empty)
        else $error("pop on empty stack changed count");

endmodule
